// File: hdl/circular_deque_defines.svh
// Assertion macros used by the checker file of the deque.
`ifndef CIRCULAR_DEQUE_DEFINES_SVH
`define CIRCULAR_DEQUE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define CDQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("circular_deque: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define CDQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("circular_deque: next-cycle check failed");

`endif

// File: hdl/cdq_pkg.sv
`default_nettype none
package cdq_pkg;

   localparam int DATA_W        = 32;
   localparam int OCC_W         = 5;
   localparam int DEPTH_DEFAULT = 32;
   localparam int CNT_W_DEFAULT = $clog2(DEPTH_DEFAULT);

   typedef enum logic [1:0] {
      KIND_PUSH_REAR  = 2'd0,
      KIND_PUSH_FRONT = 2'd1,
      KIND_POP_FRONT  = 2'd2,
      KIND_POP_REAR   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // What every cell of one chain does in a cycle.
   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_INSERT = 2'd1,
      OP_DELETE = 2'd2,
      OP_APPEND = 2'd3
   } cell_op_type;

   typedef struct packed {
      cell_op_type              f_op;
      cell_op_type              r_op;
      logic signed [DATA_W-1:0] value;
   } ctl_type;

endpackage
`default_nettype wire

// File: hdl/cdq_cell.sv
`default_nettype none
// One slot position of both chains: the front-ordered chain (front item in
// cell 0) and the rear-ordered chain (rear item in cell 0).
module cdq_cell #(
   parameter int CW  = cdq_pkg::CNT_W_DEFAULT,
   parameter int IDX = 0
) (
   input  wire                               clock,
   input  wire  cdq_pkg::ctl_type            ctl,
   input  wire         [CW-1:0]              held,
   input  wire  signed [cdq_pkg::DATA_W-1:0] prev_f,
   input  wire  signed [cdq_pkg::DATA_W-1:0] next_f,
   input  wire  signed [cdq_pkg::DATA_W-1:0] prev_r,
   input  wire  signed [cdq_pkg::DATA_W-1:0] next_r,
   output logic signed [cdq_pkg::DATA_W-1:0] f_out,
   output logic signed [cdq_pkg::DATA_W-1:0] r_out
);

   logic signed [cdq_pkg::DATA_W-1:0] f_ff, f_in;
   logic signed [cdq_pkg::DATA_W-1:0] r_ff, r_in;
   logic                              at_end;

   // This cell is the first free slot of a chain.
   assign at_end = (held == CW'(IDX));

   always_comb begin
      unique case (ctl.f_op)
         cdq_pkg::OP_INSERT: f_in = prev_f;
         cdq_pkg::OP_DELETE: f_in = next_f;
         cdq_pkg::OP_APPEND: f_in = at_end ? ctl.value : f_ff;
         default:            f_in = f_ff;
      endcase
   end

   always_comb begin
      unique case (ctl.r_op)
         cdq_pkg::OP_INSERT: r_in = prev_r;
         cdq_pkg::OP_DELETE: r_in = next_r;
         cdq_pkg::OP_APPEND: r_in = at_end ? ctl.value : r_ff;
         default:            r_in = r_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      f_ff <= f_in;
      r_ff <= r_in;
   end

   assign f_out = f_ff;
   assign r_out = r_ff;

endmodule
`default_nettype wire

// File: hdl/circular_deque.sv
// Channel    Handshake               Ports
// request    start high, busy low    req_kind, req_value
// response   rsp_valid, one cycle    rsp_status, rsp_popped, rsp_occupancy
//
// One request per cycle; the response is registered and shows in the cycle after
// acceptance. Both ends of the queue sit at cell 0 of one of two shifting cell
// chains, so no request has to wait and busy stays low.
// Reset clears the count and the response strobe; slot contents are not reset.
// The response side cannot stall, so nothing is ever held back.
`default_nettype none
module circular_deque #(
   parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               start,
   output logic                              busy,
   input  wire         [1:0]                 req_kind,
   input  wire  signed [cdq_pkg::DATA_W-1:0] req_value,
   output logic                              rsp_valid,
   output logic        [1:0]                 rsp_status,
   output logic signed [cdq_pkg::DATA_W-1:0] rsp_popped,
   output logic        [cdq_pkg::OCC_W-1:0]  rsp_occupancy
);

   localparam int CW    = $clog2(DEPTH);
   localparam int NCELL = DEPTH - 1;

   logic [CW-1:0] held_ff, held_in;
   logic          accept;
   logic          full;
   logic          empty;

   cdq_pkg::ctl_type                  ctl;
   cdq_pkg::status_type               status_in;
   logic signed [cdq_pkg::DATA_W-1:0] popped_in;

   logic                              rsp_valid_ff;
   cdq_pkg::status_type               rsp_status_ff;
   logic signed [cdq_pkg::DATA_W-1:0] rsp_popped_ff;
   logic        [cdq_pkg::OCC_W-1:0]  rsp_occ_ff;

   logic signed [cdq_pkg::DATA_W-1:0] f_q [NCELL];
   logic signed [cdq_pkg::DATA_W-1:0] r_q [NCELL];

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign full   = (held_ff == CW'(DEPTH - 1));
   assign empty  = (held_ff == '0);

   always_comb begin
      ctl.f_op  = cdq_pkg::OP_HOLD;
      ctl.r_op  = cdq_pkg::OP_HOLD;
      ctl.value = req_value;
      status_in = cdq_pkg::STATUS_OK;
      popped_in = '0;
      held_in   = held_ff;
      if (accept) begin
         unique case (cdq_pkg::kind_type'(req_kind))
            cdq_pkg::KIND_PUSH_REAR: begin
               if (full) begin
                  status_in = cdq_pkg::STATUS_FULL;
               end else begin
                  ctl.f_op = cdq_pkg::OP_APPEND;
                  ctl.r_op = cdq_pkg::OP_INSERT;
                  held_in  = held_ff + CW'(1);
               end
            end
            cdq_pkg::KIND_PUSH_FRONT: begin
               if (full) begin
                  status_in = cdq_pkg::STATUS_FULL;
               end else begin
                  ctl.f_op = cdq_pkg::OP_INSERT;
                  ctl.r_op = cdq_pkg::OP_APPEND;
                  held_in  = held_ff + CW'(1);
               end
            end
            cdq_pkg::KIND_POP_FRONT: begin
               if (empty) begin
                  status_in = cdq_pkg::STATUS_EMPTY;
               end else begin
                  // rear chain just drops its last slot through the count
                  popped_in = f_q[0];
                  ctl.f_op  = cdq_pkg::OP_DELETE;
                  held_in   = held_ff - CW'(1);
               end
            end
            default: begin
               if (empty) begin
                  status_in = cdq_pkg::STATUS_EMPTY;
               end else begin
                  popped_in = r_q[0];
                  ctl.r_op  = cdq_pkg::OP_DELETE;
                  held_in   = held_ff - CW'(1);
               end
            end
         endcase
      end
   end

   for (genvar i = 0; i < NCELL; i++) begin : g_cell
      logic signed [cdq_pkg::DATA_W-1:0] prev_f, next_f, prev_r, next_r;

      if (i == 0) begin : g_first
         assign prev_f = req_value;
         assign prev_r = req_value;
      end else begin : g_mid
         assign prev_f = f_q[i-1];
         assign prev_r = r_q[i-1];
      end

      if (i == NCELL - 1) begin : g_last
         assign next_f = f_q[i];
         assign next_r = r_q[i];
      end else begin : g_inner
         assign next_f = f_q[i+1];
         assign next_r = r_q[i+1];
      end

      cdq_cell #(
         .CW  (CW),
         .IDX (i)
      ) u_cell (
         .clock  (clock),
         .ctl    (ctl),
         .held   (held_ff),
         .prev_f (prev_f),
         .next_f (next_f),
         .prev_r (prev_r),
         .next_r (next_r),
         .f_out  (f_q[i]),
         .r_out  (r_q[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         held_ff      <= held_in;
         rsp_valid_ff <= accept;
      end
      rsp_status_ff <= status_in;
      rsp_popped_ff <= popped_in;
      rsp_occ_ff    <= cdq_pkg::OCC_W'(held_in);
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_popped    = rsp_popped_ff;
   assign rsp_occupancy = rsp_occ_ff;

endmodule
`default_nettype wire

// File: hdl/cdq_checker.sv
`default_nettype none
`include "circular_deque_defines.svh"
module cdq_checker #(
   parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
   input wire                               clock,
   input wire                               reset,
   input wire                               start,
   input wire                               busy,
   input wire                               rsp_valid,
   input wire        [1:0]                  rsp_status,
   input wire signed [cdq_pkg::DATA_W-1:0]  rsp_popped,
   input wire        [cdq_pkg::OCC_W-1:0]   rsp_occupancy
);

   logic acc;
   logic failed;

   assign acc    = !reset && start && !busy;
   assign failed = (rsp_status == cdq_pkg::STATUS_FULL) ||
                   (rsp_status == cdq_pkg::STATUS_EMPTY);

   `CDQ_ASSERT_NEXT(a_rsp_follows, clock, reset, acc, rsp_valid)
   `CDQ_ASSERT_NEXT(a_no_spurious, clock, reset, !reset && !acc, !rsp_valid)
   `CDQ_ASSERT_NOW(a_fail_zero, clock, reset, rsp_valid && failed, rsp_popped == '0)
   `CDQ_ASSERT_NOW(a_full_occ, clock, reset, rsp_valid && rsp_status == cdq_pkg::STATUS_FULL, rsp_occupancy == cdq_pkg::OCC_W'(DEPTH - 1))
   `CDQ_ASSERT_NOW(a_empty_occ, clock, reset, rsp_valid && rsp_status == cdq_pkg::STATUS_EMPTY, rsp_occupancy == '0)

endmodule

bind circular_deque cdq_checker #(
   .DEPTH (DEPTH)
) u_cdq_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_valid     (rsp_valid),
   .rsp_status    (rsp_status),
   .rsp_popped    (rsp_popped),
   .rsp_occupancy (rsp_occupancy)
);
`default_nettype wire
